>>> hw/rtl/cltlb_pkg.sv
package cltlb_pkg;

  localparam int HIST_BINS_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int CLIP_W = 17;
  localparam int SCALE_W = 24;
  localparam int SHIFT_W = 5;
  localparam int BINS_W = 9;
  localparam int COUNT_W = 17;
  localparam int LUT_W = 8;
  localparam int MODE_W = 2;
  localparam int PIX_W = 16;
  localparam int BIN_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W = 26;
  localparam int EXC_W = 26;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CLIP_RD,
    ST_CLIP,
    ST_DIV,
    ST_STEP,
    ST_MAP_RD,
    ST_MAP,
    ST_MUL,
    ST_READ,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/cltlb_in_if.sv
interface cltlb_in_if;
  logic valid;
  logic ready;
  logic [cltlb_pkg::MODE_W-1:0] mode;
  logic [cltlb_pkg::PIX_W-1:0] pixel;
  logic [cltlb_pkg::BIN_W-1:0] bin;
  modport source (output valid, mode, pixel, bin, input ready);
  modport sink (input valid, mode, pixel, bin, output ready);
endinterface

>>> hw/rtl/cltlb_out_if.sv
interface cltlb_out_if;
  logic valid;
  logic ready;
  logic [cltlb_pkg::LUT_W-1:0] lut_value;
  modport source (output valid, lut_value, input ready);
  modport sink (input valid, lut_value, output ready);
endinterface

>>> hw/rtl/cltlb_ram.sv
module cltlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/clahe_tile_lut_builder.sv
// Contrast-limited equalisation table builder for one tile.
// Channels: in (mode, pixel, bin) and out (lut_value), valid/ready; an item
// moves when both are high. Config is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must use it only while the block is idle, the block
// does not enforce it. Add-pixel item: read, modify, write of count memory.
// Read item: the table is read, then lut_value goes valid and is held
// in an output register until taken, while ready on the input stays low.
// Finish item: one walk over the bins in use for clipping, a 26-step serial
// divide of the excess by the bin count, repeated subtraction for the
// remainder stride, then a second walk with read, add, multiply and write
// per bin, which also clears each count; the bins above those in use are
// then cleared at one per cycle.
// One item at a time; the count memory read-modify-write sets the rate.
// Reset: registers go to their reset values and the block sweeps all
// HIST_BINS entries of the count memory to zero before taking items.
// Receiver stall: the result stays in the output register, no item lost.
module clahe_tile_lut_builder #(
  parameter int HIST_BINS = cltlb_pkg::HIST_BINS_DEF,
  parameter int FRAC_BITS = cltlb_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = cltlb_pkg::PIXEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [cltlb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cltlb_pkg::CFG_DATA_W-1:0] cfg_data,
  cltlb_in_if.sink    in_ch,
  cltlb_out_if.source out_ch
);
  localparam int AW = $clog2(HIST_BINS);
  localparam int NW = cltlb_pkg::BINS_W;
  localparam int SW = cltlb_pkg::SUM_W;
  localparam int EW = cltlb_pkg::EXC_W;
  localparam int PW = SW + cltlb_pkg::SCALE_W;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic [cltlb_pkg::CLIP_W-1:0]  clip_limit;
  logic [cltlb_pkg::SCALE_W-1:0] lut_scale;
  logic [cltlb_pkg::SHIFT_W-1:0] bin_shift;
  logic [NW-1:0]                 bins_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_limit <= '0;
      lut_scale <= cltlb_pkg::SCALE_W'(65536);
      bin_shift <= '0;
      bins_used <= NW'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        cltlb_pkg::REG_CLIP:  clip_limit <= cfg_data[cltlb_pkg::CLIP_W-1:0];
        cltlb_pkg::REG_SCALE: lut_scale <= cfg_data[cltlb_pkg::SCALE_W-1:0];
        cltlb_pkg::REG_SHIFT: bin_shift <= cfg_data[cltlb_pkg::SHIFT_W-1:0];
        cltlb_pkg::REG_BINS:  bins_used <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] nbins;
  always_comb begin
    nbins = bins_used;
    if (bins_used > NW'(HIST_BINS)) nbins = NW'(HIST_BINS);
    if (bins_used < NW'(2)) nbins = NW'(2);
  end

  logic [PIXEL_BITS-1:0] pix_lo;
  logic [cltlb_pkg::PIX_W-1:0] pix_sh;
  logic [AW-1:0] add_bin;
  assign pix_lo = in_ch.pixel[PIXEL_BITS-1:0];
  assign pix_sh = (bin_shift >= cltlb_pkg::SHIFT_W'(PIXEL_BITS)) ? '0
                  : cltlb_pkg::PIX_W'(pix_lo >> bin_shift);
  assign add_bin = (pix_sh > cltlb_pkg::PIX_W'(nbins - 1'b1)) ? AW'(nbins - 1'b1)
                   : AW'(pix_sh);

  cltlb_pkg::state_t state, state_next;
  logic clearing;
  logic in_map;
  logic [NW-1:0] idx, idx_next;
  logic [AW-1:0] addr_reg, addr_next;
  logic [EW-1:0] excess, excess_next;
  logic [EW-1:0] rem, rem_next;
  logic [EW-1:0] batch, batch_next;
  logic [5:0] dcnt, dcnt_next;
  logic [NW-1:0] step, step_next;
  logic [NW-1:0] stride_at, stride_at_next;
  logic [NW-1:0] rest, rest_next;
  logic [SW-1:0] sum, sum_next;
  logic [PW-1:0] prod, prod_next;
  logic [cltlb_pkg::LUT_W-1:0] outv, outv_next;
  logic outvld, outvld_next;

  logic          cnt_we;
  logic [AW-1:0] cnt_wa, cnt_ra;
  logic [cltlb_pkg::COUNT_W-1:0] cnt_wd, cnt_rd;
  logic          lut_we;
  logic [AW-1:0] lut_wa, lut_ra;
  logic [cltlb_pkg::LUT_W-1:0] lut_wd, lut_rd;

  cltlb_ram #(.WIDTH(cltlb_pkg::COUNT_W), .DEPTH(HIST_BINS)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(cnt_ra), .rdata(cnt_rd));
  cltlb_ram #(.WIDTH(cltlb_pkg::LUT_W), .DEPTH(HIST_BINS)) u_map (
    .clk(clk), .we(lut_we), .waddr(lut_wa), .wdata(lut_wd),
    .raddr(lut_ra), .rdata(lut_rd));

  logic [EW-1:0] clipped;
  logic [EW-1:0] h_adj;
  logic [EW:0]   dtrial;
  logic [PW-1:0] rounded;
  logic [PW-FRAC_BITS-1:0] shifted;

  assign clipped = (clip_limit != '0 && cnt_rd > clip_limit) ? EW'(clip_limit) : EW'(cnt_rd);
  assign dtrial = {rem, excess[EW-1]} - {1'b0, EW'(nbins)};
  assign rounded = prod + HALF;
  assign shifted = rounded[PW-1:FRAC_BITS];

  always_comb begin
    h_adj = clipped;
    if (clip_limit != '0) begin
      h_adj = clipped + batch;
      if (rest != '0 && idx == stride_at) h_adj = h_adj + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cltlb_pkg::ST_IDLE;
      clearing <= 1'b1;
      outvld <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      outvld <= outvld_next;
      idx <= idx_next;
      if (clearing && idx == NW'(HIST_BINS - 1)) clearing <= 1'b0;
      else if (state == cltlb_pkg::ST_OUT && in_map && idx == nbins - 1'b1 &&
               nbins != NW'(HIST_BINS)) clearing <= 1'b1;
    end
    addr_reg <= addr_next;
    excess <= excess_next;
    rem <= rem_next;
    batch <= batch_next;
    dcnt <= dcnt_next;
    step <= step_next;
    stride_at <= stride_at_next;
    rest <= rest_next;
    sum <= sum_next;
    prod <= prod_next;
    outv <= outv_next;
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    addr_next = addr_reg;
    excess_next = excess;
    rem_next = rem;
    batch_next = batch;
    dcnt_next = dcnt;
    step_next = step;
    stride_at_next = stride_at;
    rest_next = rest;
    sum_next = sum;
    prod_next = prod;
    outv_next = outv;
    outvld_next = outvld;
    in_ch.ready = 1'b0;
    cnt_we = 1'b0;
    cnt_wa = addr_reg;
    cnt_wd = '0;
    cnt_ra = addr_reg;
    lut_we = 1'b0;
    lut_wa = idx[AW-1:0];
    lut_wd = '0;
    lut_ra = in_ch.bin[AW-1:0];
    if (outvld && out_ch.ready) outvld_next = 1'b0;
    case (state)
      cltlb_pkg::ST_IDLE: begin
        if (clearing) begin
          cnt_we = 1'b1;
          cnt_wa = idx[AW-1:0];
          idx_next = (idx == NW'(HIST_BINS - 1)) ? '0 : idx + 1'b1;
        end else begin
          in_ch.ready = !outvld;
          if (in_ch.valid && !outvld) begin
            case (in_ch.mode)
              cltlb_pkg::MODE_ADD: begin
                addr_next = add_bin;
                state_next = cltlb_pkg::ST_ADD_RD;
              end
              cltlb_pkg::MODE_FINISH: begin
                idx_next = '0;
                excess_next = '0;
                state_next = cltlb_pkg::ST_CLIP_RD;
              end
              cltlb_pkg::MODE_READ: begin
                state_next = (NW'(in_ch.bin) < NW'(HIST_BINS)) ? cltlb_pkg::ST_READ
                             : cltlb_pkg::ST_OUT;
                outv_next = '0;
              end
              default: ;
            endcase
          end
        end
      end
      cltlb_pkg::ST_ADD_RD: state_next = cltlb_pkg::ST_ADD_WR;
      cltlb_pkg::ST_ADD_WR: begin
        cnt_we = 1'b1;
        cnt_wd = (cnt_rd == cltlb_pkg::COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
        state_next = cltlb_pkg::ST_IDLE;
      end
      cltlb_pkg::ST_CLIP_RD: begin
        cnt_ra = idx[AW-1:0];
        state_next = cltlb_pkg::ST_CLIP;
      end
      cltlb_pkg::ST_CLIP: begin
        if (clip_limit != '0 && cnt_rd > clip_limit)
          excess_next = excess + EW'(cnt_rd - clip_limit);
        if (idx == nbins - 1'b1) begin
          rem_next = '0;
          dcnt_next = 6'(EW);
          state_next = cltlb_pkg::ST_DIV;
        end else begin
          idx_next = idx + 1'b1;
          state_next = cltlb_pkg::ST_CLIP_RD;
        end
      end
      cltlb_pkg::ST_DIV: begin
        if (dtrial[EW]) begin
          rem_next = {rem[EW-2:0], excess[EW-1]};
          excess_next = {excess[EW-2:0], 1'b0};
        end else begin
          rem_next = dtrial[EW-1:0];
          excess_next = {excess[EW-2:0], 1'b1};
        end
        dcnt_next = dcnt - 1'b1;
        if (dcnt == 6'd1) begin
          rest_next = NW'(dtrial[EW] ? {rem[EW-2:0], excess[EW-1]} : dtrial[EW-1:0]);
          rem_next = EW'(nbins);
          step_next = '0;
          dcnt_next = 6'(NW);
          state_next = cltlb_pkg::ST_STEP;
        end
      end
      cltlb_pkg::ST_STEP: begin
        batch_next = excess;
        if (rest == '0) begin
          state_next = cltlb_pkg::ST_MAP_RD;
          idx_next = '0;
          sum_next = '0;
          stride_at_next = '0;
          step_next = NW'(1);
        end else if (NW'(rem) >= rest) begin
          rem_next = rem - EW'(rest);
          step_next = step + 1'b1;
        end else begin
          if (step == '0) step_next = NW'(1);
          idx_next = '0;
          sum_next = '0;
          stride_at_next = '0;
          state_next = cltlb_pkg::ST_MAP_RD;
        end
      end
      cltlb_pkg::ST_MAP_RD: begin
        cnt_ra = idx[AW-1:0];
        state_next = cltlb_pkg::ST_MAP;
      end
      cltlb_pkg::ST_MAP: begin
        sum_next = sum + SW'(h_adj);
        if (clip_limit != '0 && rest != '0 && idx == stride_at) begin
          rest_next = rest - 1'b1;
          stride_at_next = stride_at + step;
        end
        cnt_we = 1'b1;
        cnt_wa = idx[AW-1:0];
        state_next = cltlb_pkg::ST_MUL;
      end
      cltlb_pkg::ST_MUL: begin
        prod_next = PW'(sum) * PW'(lut_scale);
        state_next = cltlb_pkg::ST_OUT;
      end
      cltlb_pkg::ST_READ: begin
        outv_next = lut_rd;
        state_next = cltlb_pkg::ST_OUT;
      end
      cltlb_pkg::ST_OUT: begin
        if (in_map) begin
          lut_we = 1'b1;
          lut_wd = (shifted > (PW-FRAC_BITS)'(nbins - 1'b1)) ?
                   cltlb_pkg::LUT_W'(nbins - 1'b1) : cltlb_pkg::LUT_W'(shifted);
          if (idx == nbins - 1'b1) begin
            idx_next = (nbins == NW'(HIST_BINS)) ? '0 : idx + 1'b1;
            state_next = cltlb_pkg::ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            state_next = cltlb_pkg::ST_MAP_RD;
          end
        end else begin
          outvld_next = 1'b1;
          state_next = cltlb_pkg::ST_IDLE;
        end
      end
      default: state_next = cltlb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) in_map <= 1'b0;
    else if (state == cltlb_pkg::ST_MAP_RD) in_map <= 1'b1;
    else if (state == cltlb_pkg::ST_IDLE) in_map <= 1'b0;
  end

  assign out_ch.valid = outvld;
  assign out_ch.lut_value = outv;
endmodule

>>> hw/rtl/cltlb_checker.sv
module cltlb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [cltlb_pkg::MODE_W-1:0] in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic [cltlb_pkg::LUT_W-1:0] out_lut_value
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_lut_value))
    else $error("result dropped while stalled");
  a_no_take_while_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("item taken while result pending");
  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode == cltlb_pkg::MODE_ADD |=> !out_valid)
    else $error("pixel item produced a result");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind clahe_tile_lut_builder cltlb_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_lut_value(out_ch.lut_value));

>>> tb/tb.sv
module tb;
  import cltlb_pkg::*;

  localparam int NBINS = 256;
  localparam int DRAIN = 1800;
  localparam longint LIMIT = 4000000;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [PIX_W-1:0] pixel;
    logic [BIN_W-1:0] bin;
    bit checked;
    logic [LUT_W-1:0] lut;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cltlb_in_if in_ch ();
  cltlb_out_if out_ch ();

  clahe_tile_lut_builder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [CLIP_W-1:0] clip_r;
  logic [SCALE_W-1:0] scale_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [BINS_W-1:0] bins_r;
  logic [COUNT_W-1:0] hist [NBINS];
  logic [LUT_W-1:0] lut_tab [NBINS];
  bit lut_written [NBINS];

  logic [LUT_W-1:0] lut_expected [$];
  bit lut_pinned [$];
  logic [LUT_W-1:0] pinned_val [$];

  int errors = 0;
  int items = 0;
  int results = 0;
  int finishes = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  bit row_checked = 1'b0;
  logic [LUT_W-1:0] row_lut = '0;

  function automatic int active_bins();
    int n;
    n = int'(bins_r);
    if (n > NBINS) n = NBINS;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic void count_pixel(logic [PIX_W-1:0] p);
    int n;
    int b;
    n = active_bins();
    b = int'(p) >> shift_r;
    if (b > n - 1) b = n - 1;
    if (hist[b] != COUNT_MAX) hist[b] = hist[b] + 1'b1;
  endfunction

  function automatic void build_table();
    longint h [NBINS];
    longint excess, batch, rest, step, sum, v;
    int n;
    n = active_bins();
    for (int i = 0; i < n; i++) h[i] = longint'(hist[i]);
    if (clip_r != 0) begin
      excess = 0;
      for (int i = 0; i < n; i++) begin
        if (h[i] > clip_r) begin
          excess += h[i] - clip_r;
          h[i] = longint'(clip_r);
        end
      end
      batch = excess / n;
      rest = excess - batch * n;
      for (int i = 0; i < n; i++) h[i] += batch;
      if (rest != 0) begin
        step = n / rest;
        if (step < 1) step = 1;
        for (int i = 0; i < n && rest > 0; i += step) begin
          h[i]++;
          rest--;
        end
      end
    end
    sum = 0;
    for (int i = 0; i < n; i++) begin
      sum += h[i];
      v = (sum * longint'(scale_r) + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
      if (v > n - 1) v = longint'(n - 1);
      lut_tab[i] = v[LUT_W-1:0];
      lut_written[i] = 1'b1;
    end
    for (int i = 0; i < NBINS; i++) hist[i] = '0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      case (in_ch.mode)
        MODE_ADD: count_pixel(in_ch.pixel);
        MODE_FINISH: begin
          build_table();
          finishes++;
        end
        MODE_READ: begin
          lut_expected.push_back(lut_tab[in_ch.bin]);
          lut_pinned.push_back(row_checked);
          pinned_val.push_back(row_lut);
        end
        default: ;
      endcase
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      results++;
      if (lut_expected.size() == 0) begin
        $error("lut_value: nothing expected, got %0d", out_ch.lut_value);
        errors++;
      end else begin
        if (out_ch.lut_value !== lut_expected[0]) begin
          $error("lut_value: expected %0d, got %0d", lut_expected[0], out_ch.lut_value);
          errors++;
        end
        if (lut_pinned[0] && out_ch.lut_value !== pinned_val[0]) begin
          $error("lut_value: expected %0d, got %0d", pinned_val[0], out_ch.lut_value);
          errors++;
        end
        void'(lut_expected.pop_front());
        void'(lut_pinned.pop_front());
        void'(pinned_val.pop_front());
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!rst) stall_left <= gap_len();
    end
  end

  task automatic push(logic [MODE_W-1:0] m, logic [PIX_W-1:0] p, logic [BIN_W-1:0] b,
                      bit chk, logic [LUT_W-1:0] val, bit paced);
    int g;
    g = paced ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.pixel <= p;
    in_ch.bin <= b;
    row_checked <= chk;
    row_lut <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (m != MODE_UNUSED) items++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    row_checked <= 1'b0;
    wait (lut_expected.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CLIP: clip_r = val[CLIP_W-1:0];
      REG_SCALE: scale_r = val[SCALE_W-1:0];
      REG_SHIFT: shift_r = val[SHIFT_W-1:0];
      REG_BINS: bins_r = val[BINS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic read_some(int k);
    int b;
    repeat (k) begin
      do b = $urandom_range(0, NBINS - 1); while (!lut_written[b]);
      push(MODE_READ, PIX_W'($urandom), b[BIN_W-1:0], 1'b0, '0, 1'b1);
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(logic [PIX_W-1:0] hot);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return hot;
    if (r < 55) return (r < 50) ? 16'h0000 : 16'hFFFF;
    return PIX_W'($urandom);
  endfunction

  row_t rows [20] = '{
    '{MODE_FINISH, 16'h0000, 8'h00, 1'b0, 8'd0},
    '{MODE_READ,   16'h0000, 8'h00, 1'b1, 8'd0},
    '{MODE_READ,   16'hFFFF, 8'hFF, 1'b1, 8'd0},
    '{MODE_ADD,    16'h0000, 8'hFF, 1'b0, 8'd0},
    '{MODE_ADD,    16'hFFFF, 8'h00, 1'b0, 8'd0},
    '{MODE_ADD,    16'h5555, 8'h55, 1'b0, 8'd0},
    '{MODE_ADD,    16'hAAAA, 8'hAA, 1'b0, 8'd0},
    '{MODE_UNUSED, 16'hFFFF, 8'hFF, 1'b0, 8'd0},
    '{MODE_FINISH, 16'h1234, 8'h12, 1'b0, 8'd0},
    '{MODE_READ,   16'h0000, 8'h00, 1'b1, 8'd1},
    '{MODE_READ,   16'h0000, 8'hFE, 1'b1, 8'd1},
    '{MODE_READ,   16'h0000, 8'hFF, 1'b1, 8'd4},
    '{MODE_READ,   16'h0000, 8'h55, 1'b0, 8'd0},
    '{MODE_READ,   16'h0000, 8'hAA, 1'b0, 8'd0},
    '{MODE_UNUSED, 16'h0000, 8'h00, 1'b0, 8'd0},
    '{MODE_ADD,    16'h8000, 8'h00, 1'b0, 8'd0},
    '{MODE_ADD,    16'h7FFF, 8'h00, 1'b0, 8'd0},
    '{MODE_FINISH, 16'h0000, 8'h00, 1'b0, 8'd0},
    '{MODE_READ,   16'h0000, 8'h7F, 1'b0, 8'd0},
    '{MODE_READ,   16'h0000, 8'h80, 1'b0, 8'd0}
  };

  initial begin
    int tiles;
    int npix;
    logic [PIX_W-1:0] hot;
    clip_r = '0;
    scale_r = 24'd65536;
    shift_r = '0;
    bins_r = 9'd256;
    for (int i = 0; i < NBINS; i++) begin
      hist[i] = '0;
      lut_tab[i] = '0;
      lut_written[i] = 1'b0;
    end
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.pixel = '0;
    in_ch.bin = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    calm = 1'b1;
    foreach (rows[i]) push(rows[i].mode, rows[i].pixel, rows[i].bin,
                           rows[i].checked, rows[i].lut, 1'b1);
    settle();

    for (int ph = 0; items < 1750; ph++) begin
      calm = (ph % 5 == 2);
      case (ph % 6)
        0: write_reg(REG_CLIP, 24'd1);
        1: write_reg(REG_CLIP, 24'd0);
        2: write_reg(REG_CLIP, 24'd65536);
        default: write_reg(REG_CLIP, CFG_DATA_W'($urandom_range(0, 40)));
      endcase
      case (ph % 5)
        0: write_reg(REG_SCALE, 24'hFFFFFF);
        1: write_reg(REG_SCALE, 24'd0);
        default: write_reg(REG_SCALE, CFG_DATA_W'($urandom_range(0, 24'h0FFFFF)));
      endcase
      case (ph % 7)
        0: write_reg(REG_SHIFT, 24'd31);
        1: write_reg(REG_SHIFT, 24'd16);
        2: write_reg(REG_SHIFT, 24'd0);
        default: write_reg(REG_SHIFT, CFG_DATA_W'($urandom_range(0, 15)));
      endcase
      case (ph % 8)
        0: write_reg(REG_BINS, 24'd0);
        1: write_reg(REG_BINS, 24'd1);
        2: write_reg(REG_BINS, 24'd2);
        3: write_reg(REG_BINS, 24'd511);
        4: write_reg(REG_BINS, 24'd300);
        5: write_reg(REG_BINS, 24'd256);
        default: write_reg(REG_BINS, CFG_DATA_W'($urandom_range(2, 256)));
      endcase
      tiles = $urandom_range(1, 3);
      repeat (tiles) begin
        npix = $urandom_range(5, 90);
        hot = PIX_W'($urandom);
        repeat (npix) begin
          if ($urandom_range(0, 29) == 0)
            push(MODE_UNUSED, PIX_W'($urandom), BIN_W'($urandom), 1'b0, '0, 1'b1);
          else
            push(MODE_ADD, pick_pixel(hot), BIN_W'($urandom), 1'b0, '0, 1'b1);
        end
        push(MODE_FINISH, PIX_W'($urandom), BIN_W'($urandom), 1'b0, '0, 1'b1);
        read_some($urandom_range(5, 25));
      end
      settle();
    end

    $display("%0d items sent, %0d table reads checked, %0d tables built", items, results,
             finishes);
    $display("covered clipping, clamped bins and shifts, scale extremes and stalls");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
